// ===== rtl/hrp_pkg.sv =====
// hrp_pkg: shared types, codes and helpers for the hex record parser
// no dependencies; imported by every hrp module

package hrp_pkg;

    localparam logic [7:0] CHAR_COLON = 8'h3A;

    typedef enum logic [3:0] {
        PH_WAIT   = 4'd0,
        PH_LEN_H  = 4'd1,
        PH_LEN_L  = 4'd2,
        PH_AHI_H  = 4'd3,
        PH_AHI_L  = 4'd4,
        PH_ALO_H  = 4'd5,
        PH_ALO_L  = 4'd6,
        PH_TYPE_H = 4'd7,
        PH_TYPE_L = 4'd8,
        PH_DATA_H = 4'd9,
        PH_DATA_L = 4'd10,
        PH_CSUM_H = 4'd11,
        PH_CSUM_L = 4'd12
    } phase_t;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    // one classified character: record start or a hex digit
    typedef struct packed {
        logic       is_colon;
        logic [3:0] nibble;
    } token_t;

    typedef struct packed {
        logic   valid;
        token_t token;
    } token_push_t;

    function automatic logic is_hex_digit(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h30) && (c <= 8'h39)) ||
            ((c >= 8'h41) && (c <= 8'h46)) ||
            ((c >= 8'h61) && (c <= 8'h66));
        return r;
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            v = c - 8'h30;
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            v = c - 8'h37;
        end
        else
        begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

// ===== rtl/hrp_if.sv =====
// hrp channel interfaces: character stream in, parsed results out
// no dependencies

interface hrp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface hrp_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    logic [7:0]  record_length;
    logic [15:0] record_address;
    logic [7:0]  record_type;
    logic [7:0]  received_checksum;
    logic [7:0]  computed_checksum;

    modport source (output valid, output kind, output data_byte, output data_index,
                    output record_length, output record_address, output record_type,
                    output received_checksum, output computed_checksum, input ready);
    modport sink   (input valid, input kind, input data_byte, input data_index,
                    input record_length, input record_address, input record_type,
                    input received_checksum, input computed_checksum, output ready);
endinterface

// ===== rtl/hrp_front.sv =====
// hrp_front: takes characters, keeps colons and hex digits as tokens
// depends on hrp_pkg and hrp_char_if

module hrp_front
    import hrp_pkg::*;
(
    hrp_char_if.sink    char_chan,
    input  logic        push_ready,
    output token_push_t push
);

    logic is_colon;
    logic is_hex;

    always_comb
    begin
        is_colon = (char_chan.char_in == CHAR_COLON);
        is_hex   = is_hex_digit(char_chan.char_in);
    end

    // other characters are dropped on accept
    assign char_chan.ready        = push_ready;
    assign push.valid             = char_chan.valid && push_ready && (is_colon || is_hex);
    assign push.token.is_colon    = is_colon;
    assign push.token.nibble      = hex_nibble(char_chan.char_in);

endmodule

// ===== rtl/hrp_queue.sv =====
// hrp_queue: small token fifo between front and back
// depends on hrp_pkg

module hrp_queue
    import hrp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  token_push_t push,
    output logic        push_ready,
    input  logic        pop,
    output logic        pop_valid,
    output token_t      pop_token
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    token_t        mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_token  = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.token;
        end
    end

endmodule

// ===== rtl/hrp_back.sv =====
// hrp_back: record state machine, byte assembly, checksum and result register
// depends on hrp_pkg and hrp_result_if

module hrp_back
    import hrp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    input  logic          tok_valid,
    input  token_t        tok,
    output logic          tok_pop,
    hrp_result_if.source  result_chan
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic        strict_reg;
    logic [3:0]  hi_reg;
    logic [3:0]  hi_next;
    logic [7:0]  len_reg;
    logic [7:0]  len_next;
    logic [15:0] addr_reg;
    logic [15:0] addr_next;
    logic [7:0]  type_reg;
    logic [7:0]  type_next;
    logic [7:0]  pos_reg;
    logic [7:0]  pos_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [7:0]  full;
    logic [7:0]  pos_inc;
    logic        digit;
    logic        emit;
    kind_t       emit_kind;

    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_index_reg;
    logic [7:0]  out_len_reg;
    logic [15:0] out_addr_reg;
    logic [7:0]  out_type_reg;
    logic [7:0]  out_rcv_reg;
    logic [7:0]  out_cmp_reg;

    assign tok_pop = tok_valid && (!out_valid_reg || result_chan.ready);
    assign digit   = tok_pop && !tok.is_colon;
    assign full    = {hi_reg, tok.nibble};
    assign pos_inc = pos_reg + 8'd1;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (tok_pop && tok.is_colon)
        begin
            phase_next = PH_LEN_H;
        end
        else if (digit)
        begin
            case (phase_reg)
                PH_LEN_H:  phase_next = PH_LEN_L;
                PH_LEN_L:  phase_next = PH_AHI_H;
                PH_AHI_H:  phase_next = PH_AHI_L;
                PH_AHI_L:  phase_next = PH_ALO_H;
                PH_ALO_H:  phase_next = PH_ALO_L;
                PH_ALO_L:  phase_next = PH_TYPE_H;
                PH_TYPE_H: phase_next = PH_TYPE_L;
                PH_TYPE_L: phase_next = (len_reg != 8'd0) ? PH_DATA_H : PH_CSUM_H;
                PH_DATA_H: phase_next = PH_DATA_L;
                PH_DATA_L: phase_next = (pos_inc >= len_reg) ? PH_CSUM_H : PH_DATA_H;
                PH_CSUM_H: phase_next = PH_CSUM_L;
                PH_CSUM_L: phase_next = strict_reg ? PH_WAIT : PH_LEN_H;
                default:   phase_next = phase_reg;
            endcase
        end
    end

    // record fields and emit decision
    always_comb
    begin
        hi_next   = hi_reg;
        len_next  = len_reg;
        addr_next = addr_reg;
        type_next = type_reg;
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        emit      = 1'b0;
        emit_kind = KIND_DATA;
        if (tok_pop && tok.is_colon)
        begin
            hi_next   = '0;
            len_next  = '0;
            addr_next = '0;
            type_next = '0;
            pos_next  = '0;
            sum_next  = '0;
        end
        else if (digit)
        begin
            case (phase_reg)
                PH_LEN_H, PH_AHI_H, PH_ALO_H, PH_TYPE_H, PH_DATA_H, PH_CSUM_H:
                begin
                    hi_next = tok.nibble;
                end
                PH_LEN_L:
                begin
                    len_next = full;
                    sum_next = sum_reg + full;
                end
                PH_AHI_L:
                begin
                    addr_next = {full, addr_reg[7:0]};
                    sum_next  = sum_reg + full;
                end
                PH_ALO_L:
                begin
                    addr_next = {addr_reg[15:8], full};
                    sum_next  = sum_reg + full;
                end
                PH_TYPE_L:
                begin
                    type_next = full;
                    sum_next  = sum_reg + full;
                    pos_next  = '0;
                end
                PH_DATA_L:
                begin
                    sum_next  = sum_reg + full;
                    pos_next  = pos_inc;
                    emit      = 1'b1;
                    emit_kind = KIND_DATA;
                end
                PH_CSUM_L:
                begin
                    emit      = 1'b1;
                    emit_kind = KIND_END;
                    if (!strict_reg)
                    begin
                        hi_next   = '0;
                        len_next  = '0;
                        addr_next = '0;
                        type_next = '0;
                        pos_next  = '0;
                        sum_next  = '0;
                    end
                end
                default:
                begin
                    hi_next = hi_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            strict_reg    <= 1'b0;
            hi_reg        <= '0;
            len_reg       <= '0;
            addr_reg      <= '0;
            type_reg      <= '0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            hi_reg    <= hi_next;
            len_reg   <= len_next;
            addr_reg  <= addr_next;
            type_reg  <= type_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            if (cfg_we)
            begin
                strict_reg <= cfg_wdata;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_kind_reg <= emit_kind;
            out_len_reg  <= len_reg;
            out_addr_reg <= addr_reg;
            out_type_reg <= type_reg;
            if (emit_kind == KIND_DATA)
            begin
                out_byte_reg  <= full;
                out_index_reg <= pos_reg;
                out_rcv_reg   <= '0;
                out_cmp_reg   <= '0;
            end
            else
            begin
                out_byte_reg  <= '0;
                out_index_reg <= '0;
                out_rcv_reg   <= full;
                out_cmp_reg   <= 8'd0 - sum_reg;
            end
        end
    end

    assign result_chan.valid             = out_valid_reg;
    assign result_chan.kind              = out_kind_reg;
    assign result_chan.data_byte         = out_byte_reg;
    assign result_chan.data_index        = out_index_reg;
    assign result_chan.record_length     = out_len_reg;
    assign result_chan.record_address    = out_addr_reg;
    assign result_chan.record_type       = out_type_reg;
    assign result_chan.received_checksum = out_rcv_reg;
    assign result_chan.computed_checksum = out_cmp_reg;

endmodule

// ===== rtl/hex_record_parser.sv =====
// hex_record_parser: top level, front classifier, token queue, record back end
// depends on hrp_pkg, hrp_if, hrp_front, hrp_queue, hrp_back
//
//  channel      dir  handshake      payload
//  char_chan    in   valid/ready    char_in[7:0]
//  result_chan  out  valid/ready    kind, data_byte, data_index, record header,
//                                   received_checksum, computed_checksum
//  cfg          in   cfg_we         cfg_wdata = strict_mode
//
// one character per cycle sustained while the queue has room; a request reaches
// the result register through the queue write, then the back end update
// the back end takes one token per cycle while the result register is empty
// or being drained; the queue absorbs QUEUE_DEPTH tokens during output stalls
// rst_n clears all control state and puts the parser in wait for colon

module hex_record_parser
    import hrp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    hrp_char_if.sink     char_chan,
    hrp_result_if.source result_chan
);

    token_push_t push;
    logic        push_ready;
    logic        tok_valid;
    logic        tok_pop;
    token_t      tok;

    hrp_front u_front (
        .char_chan  (char_chan),
        .push_ready (push_ready),
        .push       (push)
    );

    hrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop        (tok_pop),
        .pop_valid  (tok_valid),
        .pop_token  (tok)
    );

    hrp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .tok_valid   (tok_valid),
        .tok         (tok),
        .tok_pop     (tok_pop),
        .result_chan (result_chan)
    );

endmodule
